/* design/dda_pkg.sv */
// shared types and constants for the dda line rasterizer
// no dependencies; imported by dda_ctrl, dda_datapath and dda_line_rasterizer

package dda_pkg;

    localparam int COLOR_BITS = 24;
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'h00FF00;

    // input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } dda_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic start;     // latch endpoints, set up positions and divider
        logic step;      // advance both axes and load the output register
        logic div_step;  // one restoring division iteration on both axes
        logic finish;    // latch signed steps from the quotients
        logic emit;      // load first pixel of a new line into the output register
    } dda_cmd_t;

endpackage

/* design/dda_ctrl.sv */
// controller state machine for the dda line rasterizer
// depends on dda_pkg; drives dda_datapath through dda_cmd_t

module dda_ctrl
    import dda_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_action,
    output logic     m_valid,
    input  logic     m_ready,
    output dda_cmd_t cmd
);

    localparam int CW = $clog2(FRAC_BITS + 2);
    localparam logic [CW-1:0] DIV_LAST = CW'(FRAC_BITS);

    dda_state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic          out_free;
    logic          accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_action == ACT_START) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.start = accept && s_action == ACT_START;
                cmd.step  = accept && s_action == ACT_STEP;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_EMIT: begin
                cmd.finish = 1'b1;
                cmd.emit   = out_free;
            end
            default: cmd = '0;
        endcase
    end

    // iteration counter and output valid
    always_comb begin
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.start) begin
            cnt_next = DIV_LAST;
        end else if (cmd.div_step && cnt_reg != '0) begin
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.step || cmd.emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* design/dda_datapath.sv */
// datapath for the dda line rasterizer: axis setup, shared-step divider,
// position accumulators, color register and output register; depends on dda_pkg

module dda_datapath
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 9,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dda_cmd_t              cmd,
    input  logic [COORD_BITS-1:0] s_x_start,
    input  logic [COORD_BITS-1:0] s_y_start,
    input  logic [COORD_BITS-1:0] s_x_end,
    input  logic [COORD_BITS-1:0] s_y_end,
    input  logic                  cfg_valid,
    input  logic [COLOR_BITS-1:0] cfg_data,
    output logic                  m_pixel_valid,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [COLOR_BITS-1:0] m_pixel_color,
    output logic                  m_last_pixel
);

    localparam int PW = COORD_BITS + FRAC_BITS + 1;  // position, signed
    localparam int SW = FRAC_BITS + 2;               // step, signed
    localparam int QW = FRAC_BITS + 1;               // quotient magnitude
    localparam int RW = COORD_BITS + 1;              // partial remainder
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    // lane 0 is x, lane 1 is y
    logic [COORD_BITS-1:0] a_lane [2];
    logic [COORD_BITS-1:0] b_lane [2];
    logic [COORD_BITS-1:0] mag_lane [2];
    logic [PW-1:0]         pos_start [2];
    logic [PW-1:0]         pos_step [2];
    logic [SW-1:0]         step_val [2];
    logic [RW-1:0]         rem_div [2];
    logic [QW-1:0]         quo_div [2];
    logic [COORD_BITS-1:0] len;

    logic [PW-1:0]         pos_reg [2];
    logic [SW-1:0]         step_reg [2];
    logic [RW-1:0]         rem_reg [2];
    logic [QW-1:0]         quo_reg [2];
    logic                  neg_reg [2];
    logic                  zero_reg [2];
    logic [COORD_BITS-1:0] len_reg;
    logic [COORD_BITS-1:0] steps_left_reg;
    logic                  active_reg;
    logic [COLOR_BITS-1:0] color_reg;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic                  out_last_reg;

    // position truncated toward zero, clamped at zero for the -0.5 case
    function automatic logic [COORD_BITS-1:0] trunc_pos(input logic [PW-1:0] p);
        if (p[PW-1]) begin
            return '0;
        end
        return p[FRAC_BITS +: COORD_BITS];
    endfunction

    assign a_lane[0] = s_x_start;
    assign a_lane[1] = s_y_start;
    assign b_lane[0] = s_x_end;
    assign b_lane[1] = s_y_end;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            mag_lane[i] = (b_lane[i] > a_lane[i]) ? (b_lane[i] - a_lane[i])
                                                  : (a_lane[i] - b_lane[i]);
            if (b_lane[i] > a_lane[i]) begin
                pos_start[i] = {1'b0, a_lane[i], FRAC_BITS'(0)} + HALF;
            end else if (b_lane[i] < a_lane[i]) begin
                pos_start[i] = {1'b0, a_lane[i], FRAC_BITS'(0)} - HALF;
            end else begin
                pos_start[i] = {1'b0, a_lane[i], FRAC_BITS'(0)};
            end
        end
    end

    assign len = (mag_lane[0] > mag_lane[1]) ? mag_lane[0] : mag_lane[1];

    // restoring division, one quotient bit per iteration
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (rem_reg[i] >= {1'b0, len_reg}) begin
                rem_div[i] = (rem_reg[i] - {1'b0, len_reg}) << 1;
                quo_div[i] = {quo_reg[i][QW-2:0], 1'b1};
            end else begin
                rem_div[i] = rem_reg[i] << 1;
                quo_div[i] = {quo_reg[i][QW-2:0], 1'b0};
            end
            if (zero_reg[i]) begin
                step_val[i] = '0;
            end else if (neg_reg[i]) begin
                step_val[i] = SW'(0) - {1'b0, quo_reg[i]};
            end else begin
                step_val[i] = {1'b0, quo_reg[i]};
            end
            pos_step[i] = pos_reg[i] + {{(PW - SW){step_reg[i][SW-1]}}, step_reg[i]};
        end
    end

    // line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            color_reg  <= COLOR_RESET;
        end else begin
            if (cfg_valid) begin
                color_reg <= cfg_data;
            end
            if (cmd.start) begin
                active_reg <= (len != '0);
            end else if (cmd.step && active_reg && steps_left_reg == COORD_BITS'(1)) begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            len_reg        <= len;
            steps_left_reg <= len;
        end else if (cmd.step && active_reg) begin
            steps_left_reg <= steps_left_reg - COORD_BITS'(1);
        end
        for (int i = 0; i < 2; i++) begin
            if (cmd.start) begin
                pos_reg[i]  <= pos_start[i];
                rem_reg[i]  <= {1'b0, mag_lane[i]};
                quo_reg[i]  <= '0;
                neg_reg[i]  <= (a_lane[i] > b_lane[i]);
                zero_reg[i] <= (a_lane[i] == b_lane[i]);
            end else if (cmd.div_step) begin
                rem_reg[i] <= rem_div[i];
                quo_reg[i] <= quo_div[i];
            end else if (cmd.step && active_reg) begin
                pos_reg[i] <= pos_step[i];
            end
            if (cmd.finish) begin
                step_reg[i] <= step_val[i];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_valid_reg <= 1'b1;
            out_x_reg     <= trunc_pos(pos_reg[0]);
            out_y_reg     <= trunc_pos(pos_reg[1]);
            out_color_reg <= color_reg;
            out_last_reg  <= !active_reg;
        end else if (cmd.step) begin
            if (active_reg) begin
                out_valid_reg <= 1'b1;
                out_x_reg     <= trunc_pos(pos_step[0]);
                out_y_reg     <= trunc_pos(pos_step[1]);
                out_color_reg <= color_reg;
                out_last_reg  <= (steps_left_reg == COORD_BITS'(1));
            end else begin
                out_valid_reg <= 1'b0;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_color_reg <= '0;
                out_last_reg  <= 1'b0;
            end
        end
    end

    assign m_pixel_valid = out_valid_reg;
    assign m_pixel_x     = out_x_reg;
    assign m_pixel_y     = out_y_reg;
    assign m_pixel_color = out_color_reg;
    assign m_last_pixel  = out_last_reg;

endmodule

/* design/dda_line_rasterizer.sv */
// top level of the dda line rasterizer
// depends on dda_pkg, dda_ctrl and dda_datapath

// DDA line generator. A start transaction (s_action = 0) carries two endpoints;
// the longer absolute axis delta becomes the line length L, and each axis gets a
// signed step of delta / L with FRAC_BITS fraction bits, starting half a pixel
// toward its end point. The start transaction returns the first pixel; each step
// transaction (s_action = 1) advances both axes and returns the next pixel, L+1
// pixels in all, with m_last_pixel on the final one. A zero-length line returns
// a single pixel flagged last. A step with no line running returns a transaction
// with every field zero. A step loads its pixel into the output register as it is
// taken; a start first runs the divider, which produces one quotient bit per
// cycle for both axes at once. The result sits in a single output register, so
// the next transaction is taken only once that register is empty or its pixel
// is taken by m_ready in the same cycle.
// draw_color is written through cfg_valid/cfg_data, always ready; the user must
// write it only while the block is idle, which the block itself does not enforce.

module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 9,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel (draw_color)
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COLOR_BITS-1:0] cfg_data,
    // input transactions
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [COORD_BITS-1:0] s_x_start,
    input  logic [COORD_BITS-1:0] s_y_start,
    input  logic [COORD_BITS-1:0] s_x_end,
    input  logic [COORD_BITS-1:0] s_y_end,
    // pixel transactions
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_pixel_valid,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [COLOR_BITS-1:0] m_pixel_color,
    output logic                  m_last_pixel
);

    dda_cmd_t cmd;

    // color register accepts a write every cycle
    assign cfg_ready = 1'b1;

    // sequencing: accept, divide, emit
    dda_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd)
    );

    // axis setup, divider, accumulators and output register
    dda_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_x_start     (s_x_start),
        .s_y_start     (s_y_start),
        .s_x_end       (s_x_end),
        .s_y_end       (s_y_end),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_pixel_valid (m_pixel_valid),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

endmodule
